### rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate package
// Shared widths, request codes and the controller/datapath command and
// status records.
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int MAX_DIM = 8;
   localparam int IDX_W   = 3;
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int ACC_W   = 40;
   localparam int SIZE_W  = 4;

   localparam logic [IDX_W-1:0]  DIM_LAST_MAX = IDX_W'(MAX_DIM - 1);
   localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(MAX_DIM);
   localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(MAX_DIM);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic {
      REQ_LOAD    = 1'b0,
      REQ_COMPUTE = 1'b1
   } req_kind_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic             load;       // write one element of each store
      logic             issue;      // start one multiply-accumulate step
      logic             first;      // step k = 0 of an entry
      logic             last_k;     // step k = n-1 of an entry
      logic             last_elem;  // entry (n-1, n-1)
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] k;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic advance;  // pipeline moves this cycle
      logic busy;     // steps in flight or a result not yet taken
   } stat_type;

endpackage

### rtl/mma_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying load and compute requests.
// ----------------------------------------------------------------------------
interface mma_req_if;
   import mma_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [IDX_W-1:0]         row_index;
   logic [IDX_W-1:0]         col_index;
   logic signed [ELEM_W-1:0] left_value;
   logic signed [ELEM_W-1:0] right_value;
   logic signed [ACC_W-1:0]  acc_init;

   modport source (output valid, req_type, row_index, col_index, left_value,
                   right_value, acc_init, input ready);
   modport sink   (input valid, req_type, row_index, col_index, left_value,
                   right_value, acc_init, output ready);
endinterface

### rtl/mma_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying accumulated result entries.
// ----------------------------------------------------------------------------
interface mma_rsp_if;
   import mma_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        out_row;
   logic [IDX_W-1:0]        out_col;
   logic signed [ACC_W-1:0] acc_result;
   logic                    saturated;
   logic                    last;

   modport source (output valid, out_row, out_col, acc_result, saturated, last,
                   input ready);
   modport sink   (input valid, out_row, out_col, acc_result, saturated, last,
                   output ready);
endinterface

### rtl/mma_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready channel carrying the matrix size register value.
// ----------------------------------------------------------------------------
interface mma_csr_if;
   import mma_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] matrix_size;

   modport source (output valid, matrix_size, input ready);
   modport sink   (input valid, matrix_size, output ready);
endinterface

### rtl/mma_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate controller
// Holds the size register and walks the row, column and inner-product loops.
// ----------------------------------------------------------------------------
module mma_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_kind,
   output logic                       req_ready,
   input  logic                       csr_valid,
   input  logic [mma_pkg::SIZE_W-1:0] csr_data,
   output logic                       csr_ready,
   input  mma_pkg::stat_type          stat,
   output mma_pkg::cmd_type           cmd
);
   import mma_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type         state_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]  i_ff, j_ff, k_ff;
   logic [IDX_W-1:0]  dim_last;
   logic              k_end, j_end, i_end;

   // Size zero acts as one, sizes above the maximum act as the maximum.
   always_comb begin
      if (size_ff == '0) begin
         dim_last = '0;
      end else if (size_ff > SIZE_MAX) begin
         dim_last = DIM_LAST_MAX;
      end else begin
         dim_last = IDX_W'(size_ff - SIZE_W'(1));
      end
   end

   assign k_end = (k_ff == dim_last);
   assign j_end = (j_ff == dim_last);
   assign i_end = (i_ff == dim_last);

   assign req_ready = (state_ff == ST_IDLE);
   // The size only changes between computes, never under a running walk.
   assign csr_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.load      = (state_ff == ST_IDLE) && req_valid && (req_kind == REQ_LOAD);
      cmd.issue     = (state_ff == ST_RUN) && stat.advance;
      cmd.first     = (k_ff == '0);
      cmd.last_k    = k_end;
      cmd.last_elem = i_end && j_end;
      cmd.row       = i_ff;
      cmd.col       = j_ff;
      cmd.k         = k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff  <= SIZE_RESET;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            size_ff <= csr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_kind == REQ_COMPUTE)) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (stat.advance) begin
                  if (!k_end) begin
                     k_ff <= k_ff + IDX_W'(1);
                  end else begin
                     k_ff <= '0;
                     if (!j_end) begin
                        j_ff <= j_ff + IDX_W'(1);
                     end else begin
                        j_ff <= '0;
                        if (!i_end) begin
                           i_ff <= i_ff + IDX_W'(1);
                        end else begin
                           state_ff <= ST_DRAIN;
                        end
                     end
                  end
               end
            end
            ST_DRAIN: begin
               if (!stat.busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A new request is never taken while results of the last compute remain.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !stat.busy)
      else $error("request accepted while the pipeline is busy");

   // Counters stay inside the matrix in use while stepping.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (i_ff <= dim_last && j_ff <= dim_last && k_ff <= dim_last))
      else $error("loop counter beyond matrix size");

   // The final step of the walk is always the final entry's last step.
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) ##1 (state_ff == ST_DRAIN) |->
         $past(cmd.issue && cmd.last_k && cmd.last_elem))
      else $error("walk ended away from the final entry");

endmodule

### rtl/mma_datapath.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate datapath
// Element stores, multiplier pipeline, saturating accumulator and result
// register.
// ----------------------------------------------------------------------------
module mma_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mma_pkg::cmd_type                  cmd,
   output mma_pkg::stat_type                 stat,
   input  logic [mma_pkg::IDX_W-1:0]         ld_row,
   input  logic [mma_pkg::IDX_W-1:0]         ld_col,
   input  logic signed [mma_pkg::ELEM_W-1:0] ld_left,
   input  logic signed [mma_pkg::ELEM_W-1:0] ld_right,
   input  logic signed [mma_pkg::ACC_W-1:0]  ld_acc,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mma_pkg::IDX_W-1:0]         rsp_row,
   output logic [mma_pkg::IDX_W-1:0]         rsp_col,
   output logic signed [mma_pkg::ACC_W-1:0]  rsp_acc,
   output logic                              rsp_sat,
   output logic                              rsp_last
);
   import mma_pkg::*;

   logic signed [ELEM_W-1:0] left_mem  [DEPTH];
   logic signed [ELEM_W-1:0] right_mem [DEPTH];
   logic signed [ACC_W-1:0]  acc_mem   [DEPTH];

   logic advance;

   // Stage 1: registered store reads.
   logic                     s1_valid_ff;
   logic                     s1_first_ff, s1_last_k_ff, s1_last_elem_ff;
   logic [IDX_W-1:0]         s1_row_ff, s1_col_ff;
   logic signed [ELEM_W-1:0] s1_left_ff, s1_right_ff;
   logic signed [ACC_W-1:0]  s1_acc_ff;

   // Stage 2: registered product.
   logic                     s2_valid_ff;
   logic                     s2_first_ff, s2_last_k_ff, s2_last_elem_ff;
   logic [IDX_W-1:0]         s2_row_ff, s2_col_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;
   logic signed [ACC_W-1:0]  s2_acc_ff;

   // Running accumulator.
   logic signed [ACC_W-1:0]  run_acc_ff;
   logic                     run_sat_ff;

   // Result register.
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic signed [ACC_W-1:0]  rsp_acc_ff;
   logic                     rsp_sat_ff, rsp_last_ff;

   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W:0]    sum_wide;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     sat_step, sat_in;
   logic                     wb_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [ACC_W-1:0]  acc_wr_data;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.advance = advance;
      stat.busy    = s1_valid_ff || s2_valid_ff || rsp_valid_ff;
   end

   // Accumulate with saturation after each addition.
   always_comb begin
      base     = s2_first_ff ? s2_acc_ff : run_acc_ff;
      sum_wide = {base[ACC_W-1], base} + (ACC_W+1)'(s2_prod_ff);
      sat_step = (sum_wide[ACC_W] != sum_wide[ACC_W-1]);
      if (!sat_step) begin
         acc_in = sum_wide[ACC_W-1:0];
      end else if (sum_wide[ACC_W]) begin
         acc_in = ACC_MIN;
      end else begin
         acc_in = ACC_MAX;
      end
      sat_in = sat_step || (!s2_first_ff && run_sat_ff);
   end

   assign wb_en       = advance && s2_valid_ff && s2_last_k_ff;
   assign wr_addr     = cmd.load ? {ld_row, ld_col} : {s2_row_ff, s2_col_ff};
   assign acc_wr_data = cmd.load ? ld_acc : acc_in;

   // Stores.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_mem[wr_addr]  <= ld_left;
         right_mem[wr_addr] <= ld_right;
      end
      if (cmd.load || wb_en) begin
         acc_mem[wr_addr] <= acc_wr_data;
      end
      if (advance) begin
         s1_left_ff  <= left_mem[{cmd.row, cmd.k}];
         s1_right_ff <= right_mem[{cmd.k, cmd.col}];
         s1_acc_ff   <= acc_mem[{cmd.row, cmd.col}];
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_first_ff     <= cmd.first;
         s1_last_k_ff    <= cmd.last_k;
         s1_last_elem_ff <= cmd.last_elem;
         s1_row_ff       <= cmd.row;
         s1_col_ff       <= cmd.col;

         s2_first_ff     <= s1_first_ff;
         s2_last_k_ff    <= s1_last_k_ff;
         s2_last_elem_ff <= s1_last_elem_ff;
         s2_row_ff       <= s1_row_ff;
         s2_col_ff       <= s1_col_ff;
         s2_prod_ff      <= s1_left_ff * s1_right_ff;
         s2_acc_ff       <= s1_acc_ff;

         if (s2_valid_ff) begin
            run_acc_ff <= acc_in;
            run_sat_ff <= sat_in;
         end
         if (wb_en) begin
            rsp_row_ff  <= s2_row_ff;
            rsp_col_ff  <= s2_col_ff;
            rsp_acc_ff  <= acc_in;
            rsp_sat_ff  <= sat_in;
            rsp_last_ff <= s2_last_elem_ff;
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && s2_last_k_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_acc   = rsp_acc_ff;
   assign rsp_sat   = rsp_sat_ff;
   assign rsp_last  = rsp_last_ff;

   // Loads only happen with the pipeline empty.
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !stat.busy)
      else $error("load while compute in flight");

   // A step is only issued when the pipeline is moving.
   a_issue_adv: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> advance)
      else $error("step issued during a stall");

   // A finished entry reaches the result register on the next edge.
   a_wb_rsp: assert property (@(posedge clock) disable iff (reset)
      wb_en |=> (rsp_valid_ff && rsp_acc_ff == $past(acc_in)))
      else $error("finished entry not registered");

endmodule

### rtl/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate engine
// Computes Z += X * Y on square matrices of up to 8 by 8 signed Q2.14
// elements with a saturating Q12.28 accumulator.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   req_bus   in          load (row, column, X, Y, Z elements) or compute
//   rsp_bus   out         one accumulated Z entry per transfer, row-major
//   csr_bus   in          matrix size n, taken only while the engine is idle
//
// Loads may follow one another in every cycle while the engine is idle.
// A compute walks the n*n*n inner-product steps in order through the store-read,
// product and result registers, as there is one multiplier and one read port per
// store; the request channel is ready again after the last entry's transfer.
// A stalled response freezes the whole pipeline, so no entry is lost.
// The stores have no reset; reset clears the control state and sets n to 8.
//
module matrix_multiply_accumulate (
   input logic        clock,
   input logic        reset,
   mma_req_if.sink    req_bus,
   mma_rsp_if.source  rsp_bus,
   mma_csr_if.sink    csr_bus
);
   import mma_pkg::*;

   // The controller and datapath talk only through these two records.
   cmd_type  cmd;
   stat_type stat;

   // The controller owns the size register and the loop counters; it takes
   // requests only when idle, which also keeps loads off the stores while a
   // compute is reading and writing them back.
   mma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.req_type),
      .req_ready (req_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_data  (csr_bus.matrix_size),
      .csr_ready (csr_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath reads one X, one Y and one Z element per step, multiplies,
   // accumulates with saturation and writes each finished entry back to the
   // Z store as it is placed in the response register.
   mma_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .ld_row    (req_bus.row_index),
      .ld_col    (req_bus.col_index),
      .ld_left   (req_bus.left_value),
      .ld_right  (req_bus.right_value),
      .ld_acc    (req_bus.acc_init),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_row   (rsp_bus.out_row),
      .rsp_col   (rsp_bus.out_col),
      .rsp_acc   (rsp_bus.acc_result),
      .rsp_sat   (rsp_bus.saturated),
      .rsp_last  (rsp_bus.last)
   );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate testbench
// Loads matrix elements, runs compute requests at several matrix sizes and
// compares every accumulated entry with a predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mma_pkg::*;

   // One request as the driver puts it on the request channel.
   typedef struct {
      req_kind_type             kind;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [ELEM_W-1:0] left;
      logic signed [ELEM_W-1:0] right;
      logic signed [ACC_W-1:0]  acc;
   } mma_request_type;

   // One accumulated entry as the engine should return it.
   typedef struct {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [ACC_W-1:0] acc;
      logic                    sat;
      logic                    last;
   } z_entry_type;

   logic clock;
   logic reset;

   mma_req_if req_bus ();
   mma_rsp_if rsp_bus ();
   mma_csr_if csr_bus ();

   matrix_multiply_accumulate u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Requests waiting for the driver, and Z entries waiting for the engine.
   mma_request_type pending_reqs[$];
   z_entry_type     z_expected[$];

   // Shadow copy of the engine: the three stores and the size register.
   logic signed [ELEM_W-1:0] x_shadow [DEPTH];
   logic signed [ELEM_W-1:0] y_shadow [DEPTH];
   logic signed [ACC_W-1:0]  z_shadow [DEPTH];
   logic [SIZE_W-1:0]        size_shadow = SIZE_RESET;

   // Handshake flags registered at the rising edge and used by the drivers
   // at the following falling edge.
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   int  mismatches = 0;
   int  req_gap    = 0;
   int  rsp_gap    = 0;
   bit  no_idle    = 1'b0;

   // Stimulus bookkeeping: which store entries hold a written value, the
   // size in effect, and how many requests have been queued.
   bit  loaded [DEPTH];
   int  cur_dim    = MAX_DIM;
   int  items_sent = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is bounded by a fixed time far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("matrix_multiply_accumulate test failed");
      $finish;
   end

   // The size register clamps: zero behaves as one and anything above the
   // largest dimension behaves as the largest dimension.
   function automatic int dim_of(input logic [SIZE_W-1:0] size);
      if (size == '0)
         return 1;
      if (size > SIZE_MAX)
         return MAX_DIM;
      return int'(size);
   endfunction

   // Most idle gaps are short; a few are long. Some phases run with none.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Applies one accepted request to the shadow state. A load writes one
   // element of each store; a compute walks the n-by-n result in row-major
   // order, adding the products in ascending k and clipping the accumulator
   // after every addition. Each entry is written back so that a repeated
   // compute accumulates again on top of it.
   function automatic void predict_request(input mma_request_type it);
      int          n;
      int          i;
      int          j;
      int          k;
      longint      acc;
      longint      hi;
      longint      lo;
      z_entry_type e;
      if (it.kind == REQ_LOAD) begin
         x_shadow[{it.row, it.col}] = it.left;
         y_shadow[{it.row, it.col}] = it.right;
         z_shadow[{it.row, it.col}] = it.acc;
         return;
      end
      n  = dim_of(size_shadow);
      hi = ACC_MAX;
      lo = ACC_MIN;
      for (i = 0; i < n; i++) begin
         for (j = 0; j < n; j++) begin
            acc   = z_shadow[i * MAX_DIM + j];
            e.sat = 1'b0;
            for (k = 0; k < n; k++) begin
               acc += longint'(x_shadow[i * MAX_DIM + k]) *
                      longint'(y_shadow[k * MAX_DIM + j]);
               if (acc > hi) begin
                  acc   = hi;
                  e.sat = 1'b1;
               end else if (acc < lo) begin
                  acc   = lo;
                  e.sat = 1'b1;
               end
            end
            z_shadow[i * MAX_DIM + j] = acc[ACC_W-1:0];
            e.row  = IDX_W'(i);
            e.col  = IDX_W'(j);
            e.acc  = acc[ACC_W-1:0];
            e.last = (i == n - 1) && (j == n - 1);
            z_expected.push_back(e);
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [ACC_W-1:0] expv,
                                       input logic [ACC_W-1:0] actv);
      if (actv !== expv) begin
         $error("%s: expected 0x%h, actual 0x%h", name, expv, actv);
         mismatches++;
      end
   endfunction

   // Compares one result transfer with the oldest expected entry.
   function automatic void check_entry();
      z_entry_type e;
      if (z_expected.size() == 0) begin
         $error("result transfer with no entry expected: row %0d col %0d",
                rsp_bus.out_row, rsp_bus.out_col);
         mismatches++;
         return;
      end
      e = z_expected.pop_front();
      check_field("out_row", ACC_W'(e.row), ACC_W'(rsp_bus.out_row));
      check_field("out_col", ACC_W'(e.col), ACC_W'(rsp_bus.out_col));
      check_field("acc_result", e.acc, rsp_bus.acc_result);
      check_field("saturated", ACC_W'(e.sat), ACC_W'(rsp_bus.saturated));
      check_field("last", ACC_W'(e.last), ACC_W'(rsp_bus.last));
   endfunction

   // Monitor: every transfer on the three channels is seen here at the rising
   // edge. Size writes and requests update the shadow state, and results are
   // checked against it.
   always @(posedge clock) begin
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      rsp_fire <= !reset && rsp_bus.valid && rsp_bus.ready;
      csr_fire <= !reset && csr_bus.valid && csr_bus.ready;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            size_shadow = csr_bus.matrix_size;
         if (req_bus.valid && req_bus.ready)
            predict_request('{req_kind_type'(req_bus.req_type), req_bus.row_index,
                              req_bus.col_index, req_bus.left_value,
                              req_bus.right_value, req_bus.acc_init});
         if (rsp_bus.valid && rsp_bus.ready)
            check_entry();
      end
   end

   // Request driver: after each transfer the request leaves the queue and a
   // random gap may follow before the next one is offered. A request that is
   // offered stays on the bus unchanged until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_fire) begin
            void'(pending_reqs.pop_front());
            req_gap = pick_gap();
         end
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_bus.valid       <= 1'b1;
            req_bus.req_type    <= pending_reqs[0].kind;
            req_bus.row_index   <= pending_reqs[0].row;
            req_bus.col_index   <= pending_reqs[0].col;
            req_bus.left_value  <= pending_reqs[0].left;
            req_bus.right_value <= pending_reqs[0].right;
            req_bus.acc_init    <= pending_reqs[0].acc;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: stalls follow a transfer, and now and then start without
   // one, so that back-pressure also lands while the engine is mid-compute.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_gap == 0 && (rsp_fire || $urandom_range(0, 7) == 0))
            rsp_gap = pick_gap();
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return '0;
         default: return ELEM_W'($urandom());
      endcase
   endfunction

   // Starting Z values lean toward the clip limits so saturation shows up.
   function automatic logic signed [ACC_W-1:0] rand_acc();
      case ($urandom_range(0, 7))
         0:       return ACC_MAX;
         1:       return ACC_MIN;
         2:       return ACC_MAX - ACC_W'($urandom_range(0, 1 << 24));
         3:       return ACC_MIN + ACC_W'($urandom_range(0, 1 << 24));
         default: return ACC_W'({$urandom(), $urandom()});
      endcase
   endfunction

   task automatic push_load(input int row, input int col, input logic signed [ELEM_W-1:0] x,
                            input logic signed [ELEM_W-1:0] y,
                            input logic signed [ACC_W-1:0] z);
      pending_reqs.push_back('{REQ_LOAD, IDX_W'(row), IDX_W'(col), x, y, z});
      loaded[row * MAX_DIM + col] = 1'b1;
      items_sent++;
   endtask

   // A compute may only read entries that were loaded, so any entry of the
   // active n-by-n region still unwritten gets a random load first. The
   // compute's own index and value fields carry noise.
   task automatic push_compute();
      int i;
      int j;
      for (i = 0; i < cur_dim; i++)
         for (j = 0; j < cur_dim; j++)
            if (!loaded[i * MAX_DIM + j])
               push_load(i, j, rand_elem(), rand_elem(), rand_acc());
      pending_reqs.push_back('{REQ_COMPUTE, IDX_W'($urandom()), IDX_W'($urandom()),
                               rand_elem(), rand_elem(), rand_acc()});
      items_sent++;
   endtask

   // Holds the sender until every request is taken and every expected entry
   // has arrived, then waits on for a trailing load to retire.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || z_expected.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // The size register is only written while the engine is idle.
   task automatic write_size(input logic [SIZE_W-1:0] size);
      wait_idle();
      csr_bus.valid       <= 1'b1;
      csr_bus.matrix_size <= size;
      do
         @(negedge clock);
      while (!csr_fire);
      csr_bus.valid <= 1'b0;
      cur_dim = dim_of(size);
   endtask

   initial begin
      int r;
      int steps;
      logic [SIZE_W-1:0] size;

      reset               = 1'b1;
      csr_bus.valid       = 1'b0;
      csr_bus.matrix_size = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest size: one product on top of Z. The first compute clips at
      // the top limit, the second at the bottom limit, and the last two
      // accumulate twice onto the written-back entry.
      write_size(SIZE_W'(1));
      push_load(0, 0, 16'sh7fff, 16'sh7fff, ACC_MAX);
      push_compute();
      push_load(0, 0, 16'sh8000, 16'sh7fff, ACC_MIN);
      push_compute();
      push_load(0, 0, 16'sh8000, 16'sh8000, '0);
      push_compute();
      push_compute();

      // Two by two: entry (0,0) clips high on the first product and comes
      // back down on the second, keeping its saturation flag. The load at
      // (7,7) lies outside the active region but is still stored.
      write_size(SIZE_W'(2));
      push_load(0, 0, 16'sh7fff, 16'sh7fff, ACC_MAX - 1);
      push_load(0, 1, 16'sh8000, 16'sh0000, ACC_MIN);
      push_load(1, 0, 16'sh7fff, 16'sh7fff, '0);
      push_load(1, 1, 16'sh0000, 16'sh8000, -1);
      push_load(7, 7, -1, -1, ACC_MAX);
      push_compute();

      // A size of zero behaves as one.
      write_size('0);
      push_compute();

      // Random phases: each picks a size, mostly small, and sends a mix of
      // loads and computes. Between phases the sender waits for the engine
      // to drain, which is also when the size changes.
      while (items_sent < 96) begin
         r = $urandom_range(0, 19);
         if (r == 0)
            size = '0;
         else if (r == 1)
            size = SIZE_W'($urandom_range(MAX_DIM + 1, (1 << SIZE_W) - 1));
         else if (r == 2)
            size = SIZE_MAX;
         else if (r < 5)
            size = SIZE_W'($urandom_range(1, MAX_DIM - 1));
         else
            size = SIZE_W'($urandom_range(1, 4));
         write_size(size);
         no_idle = ($urandom_range(0, 4) == 0);
         steps = $urandom_range(4, 16);
         repeat (steps) begin
            if ($urandom_range(0, 99) < 75) begin
               if ($urandom_range(0, 4) == 0)
                  push_load($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                            rand_elem(), rand_elem(), rand_acc());
               else
                  push_load($urandom_range(0, cur_dim - 1), $urandom_range(0, cur_dim - 1),
                            rand_elem(), rand_elem(), rand_acc());
            end else begin
               push_compute();
            end
         end
         push_compute();
      end

      // Close with the full size so the largest result matrix is seen.
      no_idle = 1'b0;
      write_size(SIZE_MAX);
      push_compute();

      wait_idle();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && z_expected.size() == 0)
         $display("matrix_multiply_accumulate test passed");
      else
         $display("matrix_multiply_accumulate test failed");
      $finish;
   end

endmodule
